/* src/gdd_pkg.sv */
package gdd_pkg;

	// Field widths
	localparam int YearBits  = 14;
	localparam int MonthBits = 4;
	localparam int DayBits   = 5;
	localparam int CountBits = 22;
	localparam int ModBits   = 9;

	localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

	// Result error codes
	localparam logic [1:0] ErrOk      = 2'd0;
	localparam logic [1:0] ErrOrder   = 2'd1;
	localparam logic [1:0] ErrEndDate = 2'd2;

	typedef struct packed {
		logic [YearBits-1:0]  start_year;
		logic [MonthBits-1:0] start_month;
		logic [DayBits-1:0]   start_day;
		logic [YearBits-1:0]  end_year;
		logic [MonthBits-1:0] end_month;
		logic [DayBits-1:0]   end_day;
	} dates_t;

	typedef struct packed {
		logic [CountBits-1:0] day_count;
		logic [1:0]           error_code;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       capture;
		logic       mod_go;
		logic       mod_sel_start;
		logic       load_walk;
		logic       step;
		logic       set_err;
		logic [1:0] err_code;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mod_busy;
		logic after;
		logic end_valid;
		logic wrap;
		logic walk_end;
	} status_t;

	// Leap rule from the year modulo 400
	function automatic logic leap_of_mod(input logic [ModBits-1:0] r);
		logic leap;
		leap = (r == ModBits'(0)) ||
			((r[1:0] == 2'd0) && (r != ModBits'(100)) && (r != ModBits'(200)) &&
			(r != ModBits'(300)));
		return leap;
	endfunction

	// Days in a month; months outside 1..12 have none
	function automatic logic [DayBits-1:0] month_len(input logic [MonthBits-1:0] m,
			input logic leap);
		logic [DayBits-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayBits'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = DayBits'(30);
			4'd2:    len = leap ? DayBits'(29) : DayBits'(28);
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

/* src/gregorian_date_difference.sv */
// Days between two Gregorian dates.
// Command channel: an item (start and end date as year, month, day) is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Result channel: done is high for exactly one cycle with result valid in that
// cycle; the transfer completes at the edge that ends it. The receiver cannot
// hold it off, so nothing ever waits on the output side.
// Result: day_count is the number of days from start to end, saturating at the
// 22-bit maximum; error_code flags a start after the end (count zero) or an
// invalid end date (count zero).
// Sequence: after the item transfer the end year is reduced modulo 400, the
// dates are checked, the start year is reduced, and a calendar walker advances
// one day per cycle from the start date until it reaches the end date or the
// count saturates; the result is then shown. Errors, and a start just before
// year zero, skip the walk and report straight after the check. A new item is
// taken no earlier than the cycle after done, so an item is never taken while
// the last one is still in progress.
// Reset: arst_n clears the controller to idle; busy is low and no result is
// pending afterwards.
module gregorian_date_difference (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gdd_pkg::dates_t  dates,
	output logic             busy,
	output logic             done,
	output gdd_pkg::result_t result
);
	import gdd_pkg::*;

	cmd_t    cmd;
	status_t status;

	gdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gdd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.dates  (dates),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

/* src/gdd_yearmod.sv */
module gdd_yearmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [gdd_pkg::YearBits-1:0] year,
	output logic                         busy,
	output logic [gdd_pkg::ModBits-1:0]  rem
);
	import gdd_pkg::*;

	localparam int Shift     = YearBits + 9;
	localparam int RecipBits = YearBits + 1;
	localparam int ProdBits  = YearBits + RecipBits + 1;
	localparam int QuotBits  = YearBits - 7;
	localparam int BackBits  = YearBits + 2;
	localparam logic [RecipBits-1:0] Recip =
		RecipBits'(((64'd1 << Shift) + 64'd399) / 64'd400);

	logic [YearBits-1:0] year_q;
	logic [QuotBits-1:0] quot_q;
	logic [ModBits-1:0]  rem_q;
	logic                pend_q;
	logic [ProdBits-1:0] prod;
	logic [BackBits-1:0] back;

	// Quotient by 400 from a rounded-up reciprocal, exact over the year range
	assign prod = ProdBits'(year) * ProdBits'(Recip);

	// Remainder from the held year and quotient
	assign back = BackBits'(year_q) - BackBits'(quot_q) * BackBits'(400);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= go;
		end
	end

	// Hold the year and its quotient, then resolve the remainder
	always_ff @(posedge clk) begin
		if (go) begin
			year_q <= year;
			quot_q <= prod[Shift +: QuotBits];
		end
		if (pend_q) begin
			rem_q <= back[ModBits-1:0];
		end
	end

	assign busy = pend_q;
	assign rem  = rem_q;

endmodule

/* src/gdd_datapath.sv */
module gdd_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  gdd_pkg::dates_t  dates,
	input  gdd_pkg::cmd_t    cmd,
	output gdd_pkg::status_t status,
	output gdd_pkg::result_t result
);
	import gdd_pkg::*;

	dates_t               dates_q;
	logic [YearBits-1:0]  walk_year_q;
	logic [MonthBits-1:0] walk_month_q;
	logic [DayBits-1:0]   walk_day_q;
	logic [ModBits-1:0]   walk_mod_q;
	logic [CountBits-1:0] count_q;
	logic [1:0]           err_q;

	logic                 mod_busy;
	logic [ModBits-1:0]   mod_rem;
	logic [YearBits-1:0]  mod_year;
	logic [DayBits-1:0]   end_len;
	logic [DayBits-1:0]   walk_len;
	logic                 at_end;

	// Shared year reduction unit
	assign mod_year = cmd.mod_sel_start ? dates_q.start_year : dates_q.end_year;

	gdd_yearmod u_yearmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mod_go),
		.year   (mod_year),
		.busy   (mod_busy),
		.rem    (mod_rem)
	);

	// Checks on the captured dates; end check uses the reduced end year
	assign end_len = month_len(dates_q.end_month, leap_of_mod(mod_rem));
	assign walk_len = month_len(walk_month_q, leap_of_mod(walk_mod_q));
	assign at_end = (walk_year_q == dates_q.end_year) &&
		(walk_month_q == dates_q.end_month) && (walk_day_q == dates_q.end_day);

	always_comb begin
		status.mod_busy  = mod_busy;
		status.after     = {dates_q.start_year, dates_q.start_month, dates_q.start_day} >
			{dates_q.end_year, dates_q.end_month, dates_q.end_day};
		status.end_valid = (dates_q.end_month != '0) && (dates_q.end_day != '0) &&
			(dates_q.end_day <= end_len);
		// Start one day before year zero: the count stays zero
		status.wrap      = (dates_q.start_year == '0) && ((dates_q.start_month == '0) ||
			((dates_q.start_month == MonthBits'(1)) && (dates_q.start_day == '0)));
		status.walk_end  = at_end || (count_q == CountMax);
	end

	// Hold the item for the whole walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dates_q <= dates;
		end
	end

	// Calendar walker: load the start date, advance one day per step
	always_ff @(posedge clk) begin
		if (cmd.load_walk) begin
			walk_year_q  <= dates_q.start_year;
			walk_month_q <= dates_q.start_month;
			walk_day_q   <= dates_q.start_day;
			walk_mod_q   <= mod_rem;
		end else if (cmd.step) begin
			if (walk_month_q == '0) begin
				walk_month_q <= MonthBits'(1);
				walk_day_q   <= DayBits'(1);
			end else if ((walk_month_q >= MonthBits'(12)) && (walk_day_q >= walk_len)) begin
				walk_year_q  <= walk_year_q + 1'b1;
				walk_month_q <= MonthBits'(1);
				walk_day_q   <= DayBits'(1);
				walk_mod_q   <= (walk_mod_q == ModBits'(399)) ? '0 : walk_mod_q + 1'b1;
			end else if (walk_day_q >= walk_len) begin
				walk_month_q <= walk_month_q + 1'b1;
				walk_day_q   <= DayBits'(1);
			end else begin
				walk_day_q <= walk_day_q + 1'b1;
			end
		end
	end

	// Day count and error code of the result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			count_q <= '0;
			err_q   <= ErrOk;
		end else begin
			if (cmd.step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err_code;
			end
		end
	end

	assign result.day_count  = count_q;
	assign result.error_code = err_q;

endmodule

/* src/gdd_ctrl.sv */
module gdd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gdd_pkg::status_t status,
	output gdd_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import gdd_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StEndGo  = 3'd1;
	localparam logic [2:0] StEndMod = 3'd2;
	localparam logic [2:0] StCheck  = 3'd3;
	localparam logic [2:0] StBegGo  = 3'd4;
	localparam logic [2:0] StBegMod = 3'd5;
	localparam logic [2:0] StWalk   = 3'd6;
	localparam logic [2:0] StOut    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Sequence: reduce end year, check, reduce start year, walk, report; a failed check or a wrap reports at once
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			StIdle: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = StEndGo;
				end
			end
			StEndGo: begin
				cmd.mod_go = 1'b1;
				state_d    = StEndMod;
			end
			StEndMod: begin
				if (!status.mod_busy) begin
					state_d = StCheck;
				end
			end
			StCheck: begin
				if (status.after) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ErrOrder;
					state_d      = StOut;
				end else if (!status.end_valid) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ErrEndDate;
					state_d      = StOut;
				end else if (status.wrap) begin
					state_d = StOut;
				end else begin
					state_d = StBegGo;
				end
			end
			StBegGo: begin
				cmd.mod_go        = 1'b1;
				cmd.mod_sel_start = 1'b1;
				state_d           = StBegMod;
			end
			StBegMod: begin
				cmd.mod_sel_start = 1'b1;
				if (!status.mod_busy) begin
					cmd.load_walk = 1'b1;
					state_d       = StWalk;
				end
			end
			StWalk: begin
				if (status.walk_end) begin
					state_d = StOut;
				end else begin
					cmd.step = 1'b1;
				end
			end
			StOut: begin
				state_d = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != StIdle);
	assign done = (state_q == StOut);

endmodule
